// ===== src/sctm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache tag manager package
// Field widths, request and result codes, and the types shared by the
// controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package sctm_pkg;

	localparam int unsigned NUM_ENTRIES_DEF = 8;
	localparam int unsigned AGE_BITS_DEF    = 16;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned DRIVE_W  = 8;
	localparam int unsigned SECTOR_W = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned CMD_W    = 2;

	// Drive number that marks an empty entry.
	localparam logic [DRIVE_W-1:0] VACANT_DRIVE = 8'hFF;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MARK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WB_ONE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WB_ALL = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_CACHED  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_DISK     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_RANGE       = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_READ_ISSUED = 3'd4;

	// Disk commands.
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WB    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_EVICT,
		ST_FILL,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOOKUP,
		OP_SCAN_STEP,
		OP_EVICT_WB,
		OP_FILL,
		OP_FLUSH_STEP
	} dp_op_t;

	typedef struct packed {
		logic in_kind_valid;
		logic in_is_flush;
		logic out_free;
		logic need_scan;
		logic scan_last;
		logic victim_dirty;
		logic flush_needs_out;
		logic flush_done;
	} sctm_status_t;

endpackage

// ===== src/sctm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one cache request item.
// ----------------------------------------------------------------------------
interface sctm_req_if;
	import sctm_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [DRIVE_W-1:0]  drive;
	logic [SECTOR_W-1:0] sector;
	logic                disk_present;
	logic [SECTOR_W-1:0] disk_sectors;

	modport source (output valid, kind, drive, sector, disk_present, disk_sectors,
		input ready);
	modport sink (input valid, kind, drive, sector, disk_present, disk_sectors,
		output ready);
endinterface

// ===== src/sctm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item of the cache tag manager.
// ----------------------------------------------------------------------------
interface sctm_rsp_if;
	import sctm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic                hit;
	logic [CMD_W-1:0]    command;
	logic [DRIVE_W-1:0]  cmd_drive;
	logic [SECTOR_W-1:0] cmd_sector;
	logic                last;

	modport source (output valid, status, slot, hit, command, cmd_drive, cmd_sector,
		last, input ready);
	modport sink (input valid, status, slot, hit, command, cmd_drive, cmd_sector,
		last, output ready);
endinterface

// ===== src/sctm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache tag manager controller
// State machine that sequences lookup, victim scan, eviction and flush.
// ----------------------------------------------------------------------------
module sctm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sctm_pkg::sctm_status_t status,
	output sctm_pkg::dp_op_t      op
);
	import sctm_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!status.in_kind_valid) begin
						state_next = ST_IDLE;
					end else if (status.in_is_flush) begin
						state_next = ST_FLUSH;
					end else begin
						state_next = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (status.out_free) begin
					state_next = status.need_scan ? ST_SCAN : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_next = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (status.out_free) begin
					state_next = status.victim_dirty ? ST_FILL : ST_IDLE;
				end
			end
			ST_FILL: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if ((!status.flush_needs_out || status.out_free) && status.flush_done) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op       = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_CAPTURE;
				end
			end
			ST_LOOKUP: begin
				if (status.out_free) begin
					op = OP_LOOKUP;
				end
			end
			ST_SCAN: begin
				op = OP_SCAN_STEP;
			end
			ST_EVICT: begin
				if (status.out_free) begin
					op = status.victim_dirty ? OP_EVICT_WB : OP_FILL;
				end
			end
			ST_FILL: begin
				if (status.out_free) begin
					op = OP_FILL;
				end
			end
			ST_FLUSH: begin
				if (!status.flush_needs_out || status.out_free) begin
					op = OP_FLUSH_STEP;
				end
			end
			default: begin
				op = OP_NONE;
			end
		endcase
	end

endmodule

// ===== src/sctm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache tag manager datapath
// Entry tags, ages and marks, the request register, the victim scan
// registers and the result register.
// ----------------------------------------------------------------------------
module sctm_datapath #(
	parameter int unsigned NUM_ENTRIES = sctm_pkg::NUM_ENTRIES_DEF,
	parameter int unsigned AGE_BITS    = sctm_pkg::AGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sctm_pkg::dp_op_t                op,
	output sctm_pkg::sctm_status_t          status,
	input  logic [sctm_pkg::KIND_W-1:0]     req_kind,
	input  logic [sctm_pkg::DRIVE_W-1:0]    req_drive,
	input  logic [sctm_pkg::SECTOR_W-1:0]   req_sector,
	input  logic                            req_present,
	input  logic [sctm_pkg::SECTOR_W-1:0]   req_nsec,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [sctm_pkg::STATUS_W-1:0]   rsp_status,
	output logic [sctm_pkg::SLOT_W-1:0]     rsp_slot,
	output logic                            rsp_hit,
	output logic [sctm_pkg::CMD_W-1:0]      rsp_command,
	output logic [sctm_pkg::DRIVE_W-1:0]    rsp_cmd_drive,
	output logic [sctm_pkg::SECTOR_W-1:0]   rsp_cmd_sector,
	output logic                            rsp_last
);
	import sctm_pkg::*;

	localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
	localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

	// Registered request.
	logic [KIND_W-1:0]   kind_q;
	logic [DRIVE_W-1:0]  drive_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                present_q;
	logic [SECTOR_W-1:0] nsec_q;

	// Entry state.
	logic [DRIVE_W-1:0]  tag_drive_q  [NUM_ENTRIES];
	logic [SECTOR_W-1:0] tag_sector_q [NUM_ENTRIES];
	logic [AGE_BITS-1:0] age_q        [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] dirty_q;
	logic [NUM_ENTRIES-1:0] loaded_q;

	// Entry pointer, shared by the victim scan, eviction and flush.
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic                found_q;

	// Result register.
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                hit_q;
	logic [CMD_W-1:0]    command_q;
	logic [DRIVE_W-1:0]  cmd_drive_q;
	logic [SECTOR_W-1:0] cmd_sector_q;
	logic                last_q;

	logic [NUM_ENTRIES-1:0] occ;
	logic [NUM_ENTRIES-1:0] match;
	logic [NUM_ENTRIES-1:0] above;
	logic [NUM_ENTRIES-1:0] dirty_occ;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   hit_dirty;
	logic                   hit_loaded;
	logic                   dirty_above;
	logic [AGE_BITS-1:0]    cur_age;
	logic [DRIVE_W-1:0]     cur_drive;
	logic [SECTOR_W-1:0]    cur_sector;
	logic                   cur_dirty;
	logic                   in_range;
	logic                   need_scan;
	logic                   scan_take;
	logic [IDX_W-1:0]       cand_idx;
	logic                   rsp_free;
	logic                   is_open_lookup;

	logic                   emit;
	logic [STATUS_W-1:0]    res_status;
	logic [IDX_W-1:0]       res_idx;
	logic                   res_hit;
	logic [CMD_W-1:0]       res_command;
	logic [DRIVE_W-1:0]     res_drive;
	logic [SECTOR_W-1:0]    res_sector;
	logic                   res_last;
	logic [SLOT_W+IDX_W-1:0] slot_ext;

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			occ[i]   = (tag_drive_q[i] != VACANT_DRIVE);
			match[i] = (drive_q != VACANT_DRIVE) && (tag_drive_q[i] == drive_q) &&
				(tag_sector_q[i] == sector_q);
			above[i] = (IDX_W'(i) > idx_q);
		end
	end

	// Lowest matching entry wins; tags are unique in practice.
	always_comb begin
		hit_idx = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign dirty_occ   = dirty_q & occ;
	assign hit         = |match;
	assign hit_dirty   = |(match & dirty_q);
	assign hit_loaded  = |(match & loaded_q);
	assign dirty_above = |(dirty_occ & above);
	assign cur_age     = age_q[idx_q];
	assign cur_drive   = tag_drive_q[idx_q];
	assign cur_sector  = tag_sector_q[idx_q];
	assign cur_dirty   = dirty_occ[idx_q];
	assign in_range    = (sector_q < nsec_q);
	assign need_scan   = (kind_q == KIND_OPEN) && !hit && present_q &&
		(drive_q != VACANT_DRIVE) && in_range;
	assign scan_take   = !found_q && (best_age_q <= cur_age);
	assign cand_idx    = scan_take ? idx_q : best_idx_q;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign is_open_lookup = (op == OP_LOOKUP) && (kind_q == KIND_OPEN);

	assign status.in_kind_valid   = (req_kind <= KIND_WB_ALL);
	assign status.in_is_flush     = (req_kind == KIND_WB_ALL);
	assign status.out_free        = rsp_free;
	assign status.need_scan       = need_scan;
	assign status.scan_last       = (idx_q == LAST_IDX);
	assign status.victim_dirty    = cur_dirty;
	assign status.flush_needs_out = cur_dirty || !dirty_above;
	assign status.flush_done      = !dirty_above;

	// Result of the current step.
	always_comb begin
		emit        = 1'b0;
		res_status  = STATUS_OK;
		res_idx     = '0;
		res_hit     = 1'b0;
		res_command = CMD_NONE;
		res_drive   = '0;
		res_sector  = '0;
		res_last    = 1'b1;
		unique case (op)
			OP_LOOKUP: begin
				unique case (kind_q)
					KIND_OPEN: begin
						if (hit) begin
							emit    = 1'b1;
							res_idx = hit_idx;
							res_hit = 1'b1;
						end else if (!present_q || drive_q == VACANT_DRIVE) begin
							emit       = 1'b1;
							res_status = STATUS_NO_DISK;
						end else if (!in_range) begin
							emit       = 1'b1;
							res_status = STATUS_RANGE;
						end
					end
					KIND_READ: begin
						emit = 1'b1;
						if (!hit) begin
							res_status = STATUS_NOT_CACHED;
						end else begin
							res_idx = hit_idx;
							res_hit = 1'b1;
							if (hit_loaded) begin
								res_status = STATUS_OK;
							end else if (present_q) begin
								res_status  = STATUS_READ_ISSUED;
								res_command = CMD_READ;
								res_drive   = drive_q;
								res_sector  = sector_q;
							end else begin
								res_status = STATUS_NO_DISK;
							end
						end
					end
					KIND_MARK: begin
						emit = 1'b1;
						if (!hit) begin
							res_status = STATUS_NOT_CACHED;
						end else begin
							res_idx = hit_idx;
							res_hit = 1'b1;
						end
					end
					KIND_WB_ONE: begin
						emit = 1'b1;
						if (!hit) begin
							res_status = STATUS_NOT_CACHED;
						end else begin
							res_idx = hit_idx;
							res_hit = 1'b1;
							if (hit_dirty && !present_q) begin
								res_status = STATUS_NO_DISK;
							end else if (hit_dirty) begin
								res_command = CMD_WB;
								res_drive   = drive_q;
								res_sector  = sector_q;
							end
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			OP_EVICT_WB: begin
				emit        = 1'b1;
				res_idx     = idx_q;
				res_command = CMD_WB;
				res_drive   = cur_drive;
				res_sector  = cur_sector;
				res_last    = 1'b0;
			end
			OP_FILL: begin
				emit    = 1'b1;
				res_idx = idx_q;
			end
			OP_FLUSH_STEP: begin
				if (cur_dirty) begin
					emit        = 1'b1;
					res_idx     = idx_q;
					res_hit     = 1'b1;
					res_command = CMD_WB;
					res_drive   = cur_drive;
					res_sector  = cur_sector;
					res_last    = !dirty_above;
				end else if (!dirty_above) begin
					// Nothing dirty at all: a single empty result closes the item.
					emit = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign slot_ext = {SLOT_W'(0), res_idx};

	// Entry pointer and victim scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			best_idx_q <= '0;
			best_age_q <= '0;
			found_q    <= 1'b0;
		end else begin
			unique case (op)
				OP_CAPTURE: begin
					idx_q <= '0;
				end
				OP_LOOKUP: begin
					idx_q      <= '0;
					best_idx_q <= '0;
					best_age_q <= '0;
					found_q    <= 1'b0;
				end
				OP_SCAN_STEP: begin
					if (scan_take) begin
						best_age_q <= cur_age;
						best_idx_q <= idx_q;
					end
					if (!found_q && cur_age == AGE_MAX) begin
						found_q <= 1'b1;
					end
					// On the last entry the pointer settles on the victim.
					idx_q <= (idx_q == LAST_IDX) ? cand_idx : idx_q + 1'b1;
				end
				OP_FLUSH_STEP: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// The request register starts on the empty marker so that nothing
	// matches before the first item arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_OPEN;
			drive_q   <= VACANT_DRIVE;
			sector_q  <= '0;
			present_q <= 1'b0;
			nsec_q    <= '0;
		end else if (op == OP_CAPTURE) begin
			kind_q    <= req_kind;
			drive_q   <= req_drive;
			sector_q  <= req_sector;
			present_q <= req_present;
			nsec_q    <= req_nsec;
		end
	end

	// Entry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				tag_drive_q[i]  <= VACANT_DRIVE;
				tag_sector_q[i] <= '0;
				age_q[i]        <= AGE_MAX;
			end
			dirty_q  <= '0;
			loaded_q <= '0;
		end else begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (is_open_lookup) begin
					if (match[i]) begin
						age_q[i] <= '0;
					end else if (occ[i] && age_q[i] != AGE_MAX) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
				if (op == OP_LOOKUP && match[i]) begin
					if (kind_q == KIND_READ || kind_q == KIND_MARK) begin
						loaded_q[i] <= 1'b1;
					end
					if (kind_q == KIND_MARK) begin
						dirty_q[i] <= 1'b1;
					end
					if (kind_q == KIND_WB_ONE && present_q) begin
						dirty_q[i] <= 1'b0;
					end
				end
				if (idx_q == IDX_W'(i)) begin
					if (op == OP_EVICT_WB || op == OP_FLUSH_STEP) begin
						dirty_q[i] <= 1'b0;
					end
					if (op == OP_FILL) begin
						tag_drive_q[i]  <= drive_q;
						tag_sector_q[i] <= sector_q;
						age_q[i]        <= '0;
						dirty_q[i]      <= 1'b0;
						loaded_q[i]     <= 1'b0;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q     <= res_status;
			slot_q       <= slot_ext[SLOT_W-1:0];
			hit_q        <= res_hit;
			command_q    <= res_command;
			cmd_drive_q  <= res_drive;
			cmd_sector_q <= res_sector;
			last_q       <= res_last;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_status     = status_q;
	assign rsp_slot       = slot_q;
	assign rsp_hit        = hit_q;
	assign rsp_command    = command_q;
	assign rsp_cmd_drive  = cmd_drive_q;
	assign rsp_cmd_sector = cmd_sector_q;
	assign rsp_last       = last_q;

`ifndef NO_ASSERTIONS
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> rsp_free)
		else $error("result produced while the result register is still occupied");

	a_tags_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("request matches more than one cache entry");

	a_dirty_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		!(|(dirty_q & ~occ)))
		else $error("empty entry carries a dirty mark");

	a_fill_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FILL) |=> hit)
		else $error("freshly filled entry does not match its request");
`endif

endmodule

// ===== src/sector_cache_tag_manager.sv =====
`timescale 1ns / 1ps
// An open hit, read, mark or single write back is captured on acceptance and answered in the
// lookup step once the result register is free; a new item is taken only back in idle.
// An allocating open runs lookup, the victim scan over every entry and fill, writing a dirty
// victim back before the fill; a busy receiver adds stalls. A full flush steps one entry per
// cycle up to the last dirty entry unless held by a busy receiver, one item per dirty entry.
// Reset is asynchronous: all entries empty, ages saturated, marks cleared, no clearing pass.
// ----------------------------------------------------------------------------
// Sector cache tag manager
// Tag and policy side of a fully associative write-back disk-sector cache
// with saturating age counters for victim choice.
// ----------------------------------------------------------------------------
module sector_cache_tag_manager #(
	parameter int unsigned NUM_ENTRIES = sctm_pkg::NUM_ENTRIES_DEF,
	parameter int unsigned AGE_BITS    = sctm_pkg::AGE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sctm_req_if.sink    req,
	sctm_rsp_if.source  rsp
);
	import sctm_pkg::*;

	// The controller owns the sequencing; the datapath owns every piece of
	// entry state and performs exactly one operation per cycle as told.
	dp_op_t       op;
	sctm_status_t status;

	sctm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.op       (op)
	);

	// Every comparison against the stored tags is done in parallel, one
	// comparator per entry. Ageing of all occupied entries happens in the
	// same cycle as the lookup of an open request, so that the victim scan
	// which follows sees the aged values. The victim is the first entry whose
	// age has saturated, otherwise the last entry holding the greatest age.
	// The result register sits at the output, so a new item may be accepted
	// while the final result of the previous one still waits to be taken.
	sctm_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.AGE_BITS    (AGE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.status         (status),
		.req_kind       (req.kind),
		.req_drive      (req.drive),
		.req_sector     (req.sector),
		.req_present    (req.disk_present),
		.req_nsec       (req.disk_sectors),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_status     (rsp.status),
		.rsp_slot       (rsp.slot),
		.rsp_hit        (rsp.hit),
		.rsp_command    (rsp.command),
		.rsp_cmd_drive  (rsp.cmd_drive),
		.rsp_cmd_sector (rsp.cmd_sector),
		.rsp_last       (rsp.last)
	);

endmodule

// ===== sim/sector_cache_tag_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache tag manager testbench
// Drives cache requests into the tag manager and checks every result item
// against a cycle-free model of the tag store that the bench keeps itself.
// Directed items cover the empty cache, the error answers, hits, fills,
// reads, marks and write backs. A held-off receiver then fills the block
// up. Random traffic over a small address pool finishes the run.
// ----------------------------------------------------------------------------
module sector_cache_tag_manager_tb;
	import sctm_pkg::*;

	localparam int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF;
	localparam int unsigned AGE_BITS    = AGE_BITS_DEF;

	// Request kinds that the block takes and drops without any answer.
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	localparam logic [AGE_BITS-1:0] AGE_SAT    = '1;
	localparam logic [SECTOR_W-1:0] SECTOR_TOP = '1;

	localparam int POOL_SIZE      = 12;
	localparam int RANDOM_ITEMS   = 225;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 4 * NUM_ENTRIES + 8;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [DRIVE_W-1:0]  drive;
		logic [SECTOR_W-1:0] sector;
		logic                disk_present;
		logic [SECTOR_W-1:0] disk_sectors;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic [CMD_W-1:0]    command;
		logic [DRIVE_W-1:0]  cmd_drive;
		logic [SECTOR_W-1:0] cmd_sector;
		logic                last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	sctm_req_if req_ch ();
	sctm_rsp_if rsp_ch ();

	sector_cache_tag_manager #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.AGE_BITS(AGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #1 clk = ~clk;

	// Bench copy of the tag store. An entry is in use while its drive is not
	// the empty marker.
	logic [DRIVE_W-1:0]  cached_drive  [NUM_ENTRIES];
	logic [SECTOR_W-1:0] cached_sector [NUM_ENTRIES];
	logic [AGE_BITS-1:0] cached_age    [NUM_ENTRIES];
	logic                cached_dirty  [NUM_ENTRIES];
	logic                cached_loaded [NUM_ENTRIES];

	// Result items still owed by the block, oldest first.
	result_t pending_results[$];

	int mismatches;
	int quiet_cycles;
	int stall_left;
	// Set by a test to make the receiver hold off; taken and cleared by the
	// receiver process, which then counts the stall down on its own.
	int hold_request;
	// While set, neither side inserts random idle cycles; a hold-off request still applies.
	bit steady_flow;

	logic [DRIVE_W-1:0]  pool_drive  [POOL_SIZE];
	logic [SECTOR_W-1:0] pool_sector [POOL_SIZE];

	// ------------------------------------------------------------------
	// Tag store model
	// ------------------------------------------------------------------

	task automatic clear_cache_model();
		int i;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			cached_drive[i]  = VACANT_DRIVE;
			cached_sector[i] = '0;
			cached_age[i]    = AGE_SAT;
			cached_dirty[i]  = 1'b0;
			cached_loaded[i] = 1'b0;
		end
		pending_results.delete();
	endtask

	function automatic void queue_result(input logic [STATUS_W-1:0] status, input int slot,
			input logic hit, input logic [CMD_W-1:0] command,
			input logic [DRIVE_W-1:0] cmd_drive, input logic [SECTOR_W-1:0] cmd_sector,
			input logic last);
		result_t res;
		res.status     = status;
		res.slot       = slot[SLOT_W-1:0];
		res.hit        = hit;
		res.command    = command;
		res.cmd_drive  = cmd_drive;
		res.cmd_sector = cmd_sector;
		res.last       = last;
		pending_results.push_back(res);
	endfunction

	// The empty marker never matches, even though empty entries carry it.
	function automatic int find_entry(input logic [DRIVE_W-1:0] drive,
			input logic [SECTOR_W-1:0] sector);
		int i;
		if (drive == VACANT_DRIVE)
			return -1;
		for (i = 0; i < NUM_ENTRIES; i++)
			if (cached_drive[i] == drive && cached_sector[i] == sector)
				return i;
		return -1;
	endfunction

	// The last entry holding the greatest age wins, but the scan stops at the
	// first saturated age, so an empty entry low in the table is taken first.
	function automatic int choose_victim();
		logic [AGE_BITS-1:0] oldest;
		int victim;
		int i;
		oldest = '0;
		victim = 0;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			if (oldest <= cached_age[i]) begin
				oldest = cached_age[i];
				victim = i;
			end
			if (oldest == AGE_SAT)
				break;
		end
		return victim;
	endfunction

	// Updates the model for one accepted request and queues what it answers.
	task automatic apply_request(input request_t r);
		int e;
		int i;
		int final_dirty;
		case (r.kind)
			KIND_OPEN: begin
				for (i = 0; i < NUM_ENTRIES; i++)
					if (cached_drive[i] != VACANT_DRIVE && cached_age[i] != AGE_SAT)
						cached_age[i]++;
				e = find_entry(r.drive, r.sector);
				if (e >= 0) begin
					cached_age[e] = '0;
					queue_result(STATUS_OK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end else if (!r.disk_present || r.drive == VACANT_DRIVE) begin
					queue_result(STATUS_NO_DISK, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else if (!(r.sector < r.disk_sectors)) begin
					queue_result(STATUS_RANGE, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else begin
					e = choose_victim();
					// A dirty victim goes back to its disk before the slot is reused.
					if (cached_drive[e] != VACANT_DRIVE && cached_dirty[e])
						queue_result(STATUS_OK, e, 1'b0, CMD_WB, cached_drive[e],
							cached_sector[e], 1'b0);
					cached_drive[e]  = r.drive;
					cached_sector[e] = r.sector;
					cached_age[e]    = '0;
					cached_dirty[e]  = 1'b0;
					cached_loaded[e] = 1'b0;
					queue_result(STATUS_OK, e, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end
			end
			KIND_READ: begin
				e = find_entry(r.drive, r.sector);
				if (e < 0) begin
					queue_result(STATUS_NOT_CACHED, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else if (cached_loaded[e]) begin
					queue_result(STATUS_OK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end else begin
					// The entry counts as loaded even when the disk has gone.
					cached_loaded[e] = 1'b1;
					if (r.disk_present)
						queue_result(STATUS_READ_ISSUED, e, 1'b1, CMD_READ, r.drive,
							r.sector, 1'b1);
					else
						queue_result(STATUS_NO_DISK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end
			end
			KIND_MARK: begin
				e = find_entry(r.drive, r.sector);
				if (e < 0) begin
					queue_result(STATUS_NOT_CACHED, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else begin
					cached_dirty[e]  = 1'b1;
					cached_loaded[e] = 1'b1;
					queue_result(STATUS_OK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end
			end
			KIND_WB_ONE: begin
				e = find_entry(r.drive, r.sector);
				if (e < 0) begin
					queue_result(STATUS_NOT_CACHED, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else if (!cached_dirty[e]) begin
					queue_result(STATUS_OK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end else if (!r.disk_present) begin
					queue_result(STATUS_NO_DISK, e, 1'b1, CMD_NONE, '0, '0, 1'b1);
				end else begin
					cached_dirty[e] = 1'b0;
					queue_result(STATUS_OK, e, 1'b1, CMD_WB, cached_drive[e],
						cached_sector[e], 1'b1);
				end
			end
			KIND_WB_ALL: begin
				// Find the final dirty entry first so that its item carries last.
				final_dirty = -1;
				for (i = 0; i < NUM_ENTRIES; i++)
					if (cached_dirty[i] && cached_drive[i] != VACANT_DRIVE)
						final_dirty = i;
				if (final_dirty < 0) begin
					queue_result(STATUS_OK, 0, 1'b0, CMD_NONE, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < NUM_ENTRIES; i++) begin
						if (cached_dirty[i] && cached_drive[i] != VACANT_DRIVE) begin
							cached_dirty[i] = 1'b0;
							queue_result(STATUS_OK, i, 1'b1, CMD_WB, cached_drive[i],
								cached_sector[i], i == final_dirty);
						end
					end
				end
			end
			default: begin
				// Spare kinds leave the store alone and answer nothing.
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Idle stretch length: mostly short, now and then a long one.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic request_t make_request(input logic [KIND_W-1:0] kind,
			input logic [DRIVE_W-1:0] drive, input logic [SECTOR_W-1:0] sector,
			input logic disk_present, input logic [SECTOR_W-1:0] disk_sectors);
		request_t r;
		r.kind         = kind;
		r.drive        = drive;
		r.sector       = sector;
		r.disk_present = disk_present;
		r.disk_sectors = disk_sectors;
		return r;
	endfunction

	// A disk size strictly above the sector, so that an open is in range.
	function automatic logic [SECTOR_W-1:0] size_above(input logic [SECTOR_W-1:0] sector);
		return $urandom_range(SECTOR_TOP, sector + 1);
	endfunction

	// Offers one item and returns at the edge where it is taken. Valid is left
	// high so that a following item can go out back to back; it is lowered
	// only by the next call, when that call idles first, or at the end.
	task automatic send_request(input request_t r);
		int gap;
		gap = 0;
		if (!steady_flow && $urandom_range(0, 99) < 35)
			gap = idle_length();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= r.kind;
		req_ch.drive        <= r.drive;
		req_ch.sector       <= r.sector;
		req_ch.disk_present <= r.disk_present;
		req_ch.disk_sectors <= r.disk_sectors;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		apply_request(r);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, long hold-offs on request, and checking
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name,
			input logic [SECTOR_W-1:0] want, input logic [SECTOR_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t ns: result item with nothing expected, status 0x%0h slot 0x%0h",
				$time, rsp_ch.status, rsp_ch.slot);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			compare_field("status", SECTOR_W'(want.status), SECTOR_W'(rsp_ch.status));
			compare_field("slot", SECTOR_W'(want.slot), SECTOR_W'(rsp_ch.slot));
			compare_field("hit", SECTOR_W'(want.hit), SECTOR_W'(rsp_ch.hit));
			compare_field("command", SECTOR_W'(want.command), SECTOR_W'(rsp_ch.command));
			compare_field("cmd_drive", SECTOR_W'(want.cmd_drive),
				SECTOR_W'(rsp_ch.cmd_drive));
			compare_field("cmd_sector", want.cmd_sector, rsp_ch.cmd_sector);
			compare_field("last", SECTOR_W'(want.last), SECTOR_W'(rsp_ch.last));
		end
	endtask

	// Ready is sampled together with valid at the edge, then the next value
	// is chosen. A request from a test replaces any random stall under way.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				check_result();
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 20) begin
				stall_left = idle_length();
			end
			rsp_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Ends the run once neither channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
			$display("sector_cache_tag_manager_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Everything that an empty cache can be asked, plus the error answers of
	// open and the spare kinds, which must be dropped silently.
	task automatic test_empty_cache();
		send_request(make_request(KIND_READ, 8'd0, '0, 1'b1, '1));
		send_request(make_request(KIND_MARK, 8'd0, '0, 1'b1, '1));
		send_request(make_request(KIND_WB_ONE, 8'd0, '0, 1'b1, '1));
		send_request(make_request(KIND_WB_ALL, 8'd0, '0, 1'b1, '1));
		// The empty marker as a drive is treated as a missing disk.
		send_request(make_request(KIND_OPEN, VACANT_DRIVE, '0, 1'b1, '1));
		send_request(make_request(KIND_OPEN, 8'd17, 32'd5, 1'b0, '1));
		// Sector equal to the disk size, at the very top and at zero.
		send_request(make_request(KIND_OPEN, 8'd254, SECTOR_TOP, 1'b1, SECTOR_TOP));
		send_request(make_request(KIND_OPEN, 8'd0, '0, 1'b1, '0));
		send_request(make_request(KIND_SPARE_FIRST, 8'd1, 32'd1, 1'b1, '1));
		send_request(make_request(KIND_SPARE_LAST, 8'd2, 32'd2, 1'b0, '0));
	endtask

	// Fill two entries at the extremes of drive and sector, then walk them
	// through every read, mark and write back answer.
	task automatic test_fill_and_access();
		logic [SECTOR_W-1:0] high_sector;
		high_sector = SECTOR_TOP - 1;
		send_request(make_request(KIND_OPEN, 8'd254, high_sector, 1'b1, SECTOR_TOP));
		send_request(make_request(KIND_OPEN, 8'd254, high_sector, 1'b1, SECTOR_TOP));
		// Unloaded entry with the disk gone still becomes loaded.
		send_request(make_request(KIND_READ, 8'd254, high_sector, 1'b0, '0));
		send_request(make_request(KIND_READ, 8'd254, high_sector, 1'b1, '0));
		send_request(make_request(KIND_OPEN, 8'd0, '0, 1'b1, 32'd1));
		send_request(make_request(KIND_READ, 8'd0, '0, 1'b1, '0));
		send_request(make_request(KIND_MARK, 8'd0, '0, 1'b1, '0));
		// Dirty entry but no disk: stays dirty.
		send_request(make_request(KIND_WB_ONE, 8'd0, '0, 1'b0, '0));
		send_request(make_request(KIND_WB_ONE, 8'd0, '0, 1'b1, '0));
		send_request(make_request(KIND_WB_ONE, 8'd0, '0, 1'b1, '0));
		send_request(make_request(KIND_MARK, 8'd254, high_sector, 1'b1, '0));
		send_request(make_request(KIND_MARK, 8'd0, '0, 1'b1, '0));
		send_request(make_request(KIND_WB_ALL, 8'd0, '0, 1'b1, '0));
	endtask

	// The receiver stops for a long stretch while items keep coming without
	// gaps, so the block backs up and has to stall its request side. The
	// opens spill past the table and push a dirty entry out.
	task automatic test_backpressure();
		int i;
		logic [DRIVE_W-1:0] drive;
		logic [SECTOR_W-1:0] sector;
		steady_flow = 1'b1;
		hold_request = HOLD_CYCLES;
		send_request(make_request(KIND_MARK, 8'd254, SECTOR_TOP - 1, 1'b1, '0));
		for (i = 0; i < NUM_ENTRIES + 2; i++) begin
			drive  = DRIVE_W'($urandom_range(0, 254));
			sector = $urandom;
			if (sector == SECTOR_TOP)
				sector = '0;
			send_request(make_request(KIND_OPEN, drive, sector, 1'b1, size_above(sector)));
			if (i % 3 == 0)
				send_request(make_request(KIND_MARK, drive, sector, 1'b1, '0));
		end
		send_request(make_request(KIND_WB_ALL, 8'd0, '0, 1'b1, '0));
		steady_flow = 1'b0;
	endtask

	// Mostly well-formed traffic on a pool a little larger than the table, so
	// that hits, misses and evictions of dirty entries all occur often; the
	// rest is noise with random fields, the empty marker and spare kinds.
	function automatic request_t random_request();
		int roll;
		int p;
		logic present;
		logic [KIND_W-1:0] kind;
		logic [DRIVE_W-1:0] drive;
		roll    = $urandom_range(0, 99);
		p       = $urandom_range(0, POOL_SIZE - 1);
		present = ($urandom_range(0, 99) < 85);
		if (roll < 35)
			return make_request(KIND_OPEN, pool_drive[p], pool_sector[p],
				$urandom_range(0, 99) < 92, size_above(pool_sector[p]));
		else if (roll < 50)
			return make_request(KIND_READ, pool_drive[p], pool_sector[p], present, $urandom);
		else if (roll < 65)
			return make_request(KIND_MARK, pool_drive[p], pool_sector[p], present, $urandom);
		else if (roll < 75)
			return make_request(KIND_WB_ONE, pool_drive[p], pool_sector[p], present, $urandom);
		else if (roll < 80)
			return make_request(KIND_WB_ALL, DRIVE_W'($urandom_range(0, 255)), $urandom,
				present, $urandom);
		else if (roll < 97) begin
			kind  = KIND_W'($urandom_range(KIND_OPEN, KIND_WB_ALL));
			drive = ($urandom_range(0, 99) < 20) ? VACANT_DRIVE :
				DRIVE_W'($urandom_range(0, 255));
			return make_request(kind, drive, $urandom, 1'($urandom_range(0, 1)), $urandom);
		end else
			return make_request(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
				DRIVE_W'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)),
				$urandom);
	endfunction

	task automatic test_random_traffic();
		int i;
		int counted;
		request_t r;
		for (i = 0; i < POOL_SIZE; i++) begin
			pool_drive[i] = DRIVE_W'($urandom_range(0, 254));
			if (i % 2 == 1)
				pool_sector[i] = $urandom_range(0, 15);
			else
				pool_sector[i] = $urandom_range(0, SECTOR_TOP - 1);
		end
		// Same drive with another sector, and same sector on another drive.
		pool_drive[1]  = pool_drive[0];
		pool_sector[3] = pool_sector[2];
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			// One stretch runs with no idling on either side.
			steady_flow = (counted >= 120 && counted < 160);
			r = random_request();
			send_request(r);
			if (r.kind <= KIND_WB_ALL)
				counted++;
		end
		steady_flow = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		mismatches   = 0;
		stall_left   = 0;
		hold_request = 0;
		steady_flow  = 1'b0;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.kind         <= KIND_OPEN;
		req_ch.drive        <= '0;
		req_ch.sector       <= '0;
		req_ch.disk_present <= 1'b0;
		req_ch.disk_sectors <= '0;
		clear_cache_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_cache();
		test_fill_and_access();
		test_backpressure();
		test_random_traffic();

		// Everything has been taken; wait for the block to answer it all, then
		// a little longer in case a stray item follows.
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sector_cache_tag_manager_tb: PASS");
		else
			$display("sector_cache_tag_manager_tb: FAIL");
		$finish;
	end

endmodule
